// ----- rtl/sau_pkg.sv -----
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types, codes and constant ROM tables of the scaled activation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC_BITS  = 10;
	localparam int TAB_N      = 256;
	localparam int TAB_LOG2   = 8;
	localparam int LUT_FRAC   = 30;
	localparam int LUT_W      = 31;
	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 12;
	localparam int GUARD      = 6;
	localparam int SP_LIMIT   = 20;
	localparam int IDX_W      = 9;
	localparam int FR_W       = 7;

	localparam logic [LUT_W-1:0] Q30_ONE = LUT_W'(1) << LUT_FRAC;
	localparam logic signed [DATA_W-1:0] SP_LIM_POS = DATA_W'(SP_LIMIT << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] SP_LIM_NEG = -SP_LIM_POS;
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << SCALE_FRAC);

	// activation codes
	localparam logic [2:0] FN_IDENT    = 3'd0;
	localparam logic [2:0] FN_RELU     = 3'd1;
	localparam logic [2:0] FN_SIGMOID  = 3'd2;
	localparam logic [2:0] FN_TANH     = 3'd3;
	localparam logic [2:0] FN_SOFTPLUS = 3'd4;

	// register indexes
	localparam logic [1:0] REG_FUNC  = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;

	// table codes
	localparam logic [1:0] TAB_EXP  = 2'd0;
	localparam logic [1:0] TAB_SIG  = 2'd1;
	localparam logic [1:0] TAB_TANH = 2'd2;
	localparam logic [1:0] TAB_SPL  = 2'd3;

	typedef logic [LUT_W-1:0] rom_t [TAB_N+1];

	// shift-subtract quotient, evaluated only while the tables are built
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
		logic [64:0] rem;
		longint unsigned q;
		rem = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-f for f in [0, 1], Q30
	function automatic longint unsigned exp_frac(longint unsigned f);
		longint sum;
		longint unsigned term;
		longint unsigned one;
		one = 64'd1 << LUT_FRAC;
		sum = longint'(one);
		term = one;
		for (int k = 1; k <= 24; k++) begin
			term = udiv(term * f, longint'(k) << LUT_FRAC);
			if (k[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	// e^-t for t >= 0, Q30
	function automatic longint unsigned exp_neg(longint unsigned t, longint unsigned e1);
		longint unsigned n;
		longint unsigned r;
		n = t >> LUT_FRAC;
		r = exp_frac(t & ((64'd1 << LUT_FRAC) - 64'd1));
		while (n > 0 && r != 0) begin
			r = (r * e1) >> LUT_FRAC;
			n = n - 1;
		end
		return r;
	endfunction

	// build one table at elaboration
	function automatic rom_t build_rom(logic [1:0] sel);
		rom_t tab;
		longint unsigned one, e1, t, e, e2, z, z2, p, sum, v;
		one = 64'd1 << LUT_FRAC;
		e1 = exp_frac(one);
		for (int i = 0; i <= TAB_N; i++) begin
			t = (longint'(i) << (LUT_FRAC + 5)) >> TAB_LOG2;
			e = exp_neg(t, e1);
			e2 = exp_neg(2 * t, e1);
			if (e > one) e = one;
			if (e2 > one) e2 = one;
			// ln(1 + e) by the atanh series
			z = udiv(e << LUT_FRAC, 2 * one + e);
			z2 = (z * z) >> LUT_FRAC;
			p = z;
			sum = 0;
			for (int k = 0; k < 20; k++) begin
				sum = sum + udiv(p, longint'(2 * k + 1));
				p = (p * z2) >> LUT_FRAC;
			end
			case (sel)
				TAB_EXP:  v = e;
				TAB_SIG:  v = udiv(one << LUT_FRAC, one + e);
				TAB_TANH: v = udiv((one - e2) << LUT_FRAC, one + e2);
				default:  v = 2 * sum;
			endcase
			tab[i] = LUT_W'(v);
		end
		return tab;
	endfunction

	localparam rom_t ROM_EXP  = build_rom(TAB_EXP);
	localparam rom_t ROM_SIG  = build_rom(TAB_SIG);
	localparam rom_t ROM_TANH = build_rom(TAB_TANH);
	localparam rom_t ROM_SPL  = build_rom(TAB_SPL);

	// Q30 to Q16, round half up
	function automatic logic [16:0] to_guard(logic [LUT_W-1:0] v);
		logic [LUT_W-1:0] s;
		s = v + LUT_W'(1 << 13);
		return s[30:14];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/scaled_activation_unit.sv -----
// ----------------------------------------------------------------------------
// scaled_activation_unit
// Scaled activation and its gradient on Q5.10 elements, table interpolated.
// ----------------------------------------------------------------------------
// The result_valid strobe follows start through the lookup, interpolate,
// derivative product, scale product and final product stages.
// Throughput: one element per cycle; busy is never raised.
// The receiver cannot stall. Reset clears the valid pipeline and loads
// function_select 1 (relu) and output_scale 4096 (1.0).
`default_nettype none

module scaled_activation_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [15:0] x_value,
	input  wire logic [15:0] grad_in,
	input  wire logic        end_of_tensor,
	output logic             result_valid,
	output logic [15:0]      result_value,
	output logic             saturated,
	output logic             end_marker,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int LW = sau_pkg::LUT_W;

	logic [2:0]  func_q;
	logic [15:0] scale_q;
	logic [15:0] scale_eff;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign scale_eff = (scale_q == '0) ? sau_pkg::SCALE_ONE : scale_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q  <= sau_pkg::FN_RELU;
			scale_q <= sau_pkg::SCALE_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				sau_pkg::REG_FUNC:  func_q  <= cfg_data[2:0];
				sau_pkg::REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: table lookup ----------------
	logic signed [15:0] xs;
	logic [15:0] mag;
	logic [8:0]  idx0, idx1;
	logic [1:0]  tsel;
	logic [LW-1:0] ta, tb;
	logic        x_neg, x_pos, x_gt, x_lt;

	assign xs    = signed'(x_value);
	assign x_neg = xs < 0;
	assign x_pos = xs > 0;
	assign x_gt  = xs > sau_pkg::SP_LIM_POS;
	assign x_lt  = xs < sau_pkg::SP_LIM_NEG;
	assign mag   = x_neg ? 16'(-xs) : x_value;
	assign idx0  = mag[15:7];
	assign idx1  = (idx0 == 9'(sau_pkg::TAB_N)) ? idx0 : idx0 + 9'd1;

	// pick the table this element needs
	always_comb begin
		case (func_q)
			sau_pkg::FN_TANH: tsel = sau_pkg::TAB_TANH;
			sau_pkg::FN_SOFTPLUS: begin
				if (kind) tsel = sau_pkg::TAB_SIG;
				else if (x_lt) tsel = sau_pkg::TAB_EXP;
				else tsel = sau_pkg::TAB_SPL;
			end
			default: tsel = sau_pkg::TAB_SIG;
		endcase
	end

	always_comb begin
		case (tsel)
			sau_pkg::TAB_EXP: begin
				ta = sau_pkg::ROM_EXP[idx0];
				tb = sau_pkg::ROM_EXP[idx1];
			end
			sau_pkg::TAB_TANH: begin
				ta = sau_pkg::ROM_TANH[idx0];
				tb = sau_pkg::ROM_TANH[idx1];
			end
			sau_pkg::TAB_SPL: begin
				ta = sau_pkg::ROM_SPL[idx0];
				tb = sau_pkg::ROM_SPL[idx1];
			end
			default: begin
				ta = sau_pkg::ROM_SIG[idx0];
				tb = sau_pkg::ROM_SIG[idx1];
			end
		endcase
	end

	logic          v_s1, kind_s1, end_s1, xneg_s1, xpos_s1, xgt_s1, xlt_s1, gneg_s1;
	logic [15:0]   mag_s1, gmag_s1;
	logic [LW-1:0] a_s1, b_s1;
	logic [6:0]    f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		end_s1  <= end_of_tensor;
		xneg_s1 <= x_neg;
		xpos_s1 <= x_pos;
		xgt_s1  <= x_gt;
		xlt_s1  <= x_lt;
		gneg_s1 <= grad_in[15];
		gmag_s1 <= grad_in[15] ? 16'(-signed'(grad_in)) : grad_in;
		mag_s1  <= mag;
		a_s1    <= ta;
		b_s1    <= tb;
		f_s1    <= (idx0 == 9'(sau_pkg::TAB_N)) ? 7'd0 : mag[6:0];
	end

	// ---------------- stage 2: interpolate ----------------
	logic [LW-1:0] diff;
	logic [LW+6:0] dprod;
	logic [LW-1:0] interp;

	assign diff   = (b_s1 >= a_s1) ? b_s1 - a_s1 : a_s1 - b_s1;
	assign dprod  = diff * f_s1;
	assign interp = (b_s1 >= a_s1) ? a_s1 + dprod[LW+6:7] : a_s1 - dprod[LW+6:7];

	logic          v_s2, kind_s2, end_s2, xneg_s2, xpos_s2, xgt_s2, xlt_s2, gneg_s2;
	logic [15:0]   mag_s2, gmag_s2;
	logic [LW-1:0] l_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		end_s2  <= end_s1;
		xneg_s2 <= xneg_s1;
		xpos_s2 <= xpos_s1;
		xgt_s2  <= xgt_s1;
		xlt_s2  <= xlt_s1;
		gneg_s2 <= gneg_s1;
		gmag_s2 <= gmag_s1;
		mag_s2  <= mag_s1;
		l_s2    <= interp;
	end

	// ---------------- stage 3: base value, derivative product ----------------
	logic [LW-1:0] sadj, pa, pb;
	logic [21:0]   xg, bmag;
	logic [16:0]   tg_l, tg_s;
	logic          fneg;

	assign sadj = xneg_s2 ? sau_pkg::Q30_ONE - l_s2 : l_s2;
	assign xg   = {mag_s2, 6'd0};
	assign tg_l = sau_pkg::to_guard(l_s2);
	assign tg_s = sau_pkg::to_guard(sadj);
	assign pa   = (func_q == sau_pkg::FN_TANH) ? l_s2 : sadj;
	assign pb   = (func_q == sau_pkg::FN_TANH) ? l_s2 : sau_pkg::Q30_ONE - sadj;

	always_comb begin
		fneg = 1'b0;
		case (func_q)
			sau_pkg::FN_RELU:    bmag = xpos_s2 ? xg : '0;
			sau_pkg::FN_SIGMOID: bmag = 22'(tg_s);
			sau_pkg::FN_TANH: begin
				bmag = 22'(tg_l);
				fneg = xneg_s2;
			end
			sau_pkg::FN_SOFTPLUS: begin
				if (xgt_s2) bmag = xg;
				else if (xlt_s2) bmag = 22'(tg_l);
				else if (!xneg_s2) bmag = xg + 22'(tg_l);
				else bmag = 22'(tg_l);
			end
			default: begin
				bmag = xg;
				fneg = xneg_s2;
			end
		endcase
	end

	logic          v_s3, kind_s3, end_s3, xpos_s3, neg_s3;
	logic [15:0]   gmag_s3;
	logic [21:0]   bmag_s3;
	logic [LW-1:0] sadj_s3;
	logic [2*LW-1:0] p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		end_s3  <= end_s2;
		xpos_s3 <= xpos_s2;
		neg_s3  <= kind_s2 ? gneg_s2 : fneg;
		gmag_s3 <= gmag_s2;
		bmag_s3 <= bmag;
		sadj_s3 <= sadj;
		p_s3    <= pa * pb;
	end

	// ---------------- stage 4: derivative, scale product ----------------
	logic [LW-1:0] dq30, dsum;
	logic [16:0]   d16;

	always_comb begin
		case (func_q)
			sau_pkg::FN_RELU:     dq30 = xpos_s3 ? sau_pkg::Q30_ONE : '0;
			sau_pkg::FN_SIGMOID:  dq30 = p_s3[60:30];
			sau_pkg::FN_TANH:     dq30 = sau_pkg::Q30_ONE - p_s3[60:30];
			sau_pkg::FN_SOFTPLUS: dq30 = sadj_s3;
			default:              dq30 = sau_pkg::Q30_ONE;
		endcase
	end

	assign dsum = dq30 + LW'(1 << 13);
	assign d16  = dsum[30:14];

	logic        v_s4, kind_s4, end_s4, neg_s4;
	logic [37:0] sp_s4;
	logic [16:0] d16_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		kind_s4 <= kind_s3;
		end_s4  <= end_s3;
		neg_s4  <= neg_s3;
		d16_s4  <= d16;
		sp_s4   <= kind_s3 ? 38'(gmag_s3) * scale_eff : 38'(bmag_s3) * scale_eff;
	end

	// ---------------- stage 5: final product, round, saturate ----------------
	logic [48:0] bprod;
	logic [37:0] fsum;
	logic [21:0] rmag;
	logic [15:0] res;
	logic        sat;

	assign bprod = sp_s4[31:0] * d16_s4 + 49'(1 << 27);
	assign fsum  = sp_s4 + 38'(1 << 17);
	assign rmag  = kind_s4 ? 22'(bprod[48:28]) : 22'(fsum[37:18]);

	always_comb begin
		sat = 1'b0;
		if (neg_s4) begin
			if (rmag > 22'd32768) begin
				sat = 1'b1;
				res = 16'h8000;
			end else begin
				res = 16'(-rmag);
			end
		end else begin
			if (rmag > 22'd32767) begin
				sat = 1'b1;
				res = 16'h7FFF;
			end else begin
				res = rmag[15:0];
			end
		end
	end

	// hold the result for one strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= v_s4;
	end

	always_ff @(posedge clk) begin
		result_value <= res;
		saturated    <= sat;
		end_marker   <= end_s4;
	end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scaled_activation_unit: directed rows for the
// function and scale corners, then random forward and backward elements.
// Results are compared with a local table-driven fixed-point predictor or a row's own value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import sau_pkg::*;

	typedef struct {
		logic [15:0] value;
		logic        sat;
		logic        eot;
	} act_result_t;

	typedef struct {
		logic [2:0]  fn;
		logic [15:0] scale;
		logic        kind;
		logic [15:0] x;
		logic [15:0] g;
		logic        eot;
		bit          typed;
		logic [15:0] tv;
		logic        ts;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [15:0] x_value;
	logic [15:0] grad_in;
	logic        end_of_tensor;
	logic        result_valid;
	logic [15:0] result_value;
	logic        saturated;
	logic        end_marker;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// expected result carried alongside a directed request
	bit          typed_en;
	logic [15:0] typed_val;
	logic        typed_sat;

	logic [2:0]  fn_sel;
	logic [15:0] out_scale;
	longint unsigned rom_q30 [4][TAB_N+1];
	act_result_t expected_results [$];
	int          err_count;
	int          fwd_count;
	int          bwd_count;
	int          sat_count;
	int          result_count;

	scaled_activation_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .x_value(x_value), .grad_in(grad_in),
		.end_of_tensor(end_of_tensor), .result_valid(result_valid),
		.result_value(result_value), .saturated(saturated),
		.end_marker(end_marker), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// global run limit
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// e^-f for f in [0, 1], Q30 series
	function automatic longint unsigned series_exp(longint unsigned f);
		longint sum;
		longint unsigned term;
		sum = longint'(64'd1 << LUT_FRAC);
		term = 64'd1 << LUT_FRAC;
		for (int k = 1; k <= 24; k++) begin
			term = (term * f) / (longint'(k) << LUT_FRAC);
			if (k % 2 == 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	function automatic longint unsigned decay(longint unsigned t, longint unsigned e1);
		longint unsigned n;
		longint unsigned r;
		n = t >> LUT_FRAC;
		r = series_exp(t & ((64'd1 << LUT_FRAC) - 1));
		while (n > 0 && r != 0) begin
			r = (r * e1) >> LUT_FRAC;
			n--;
		end
		return r;
	endfunction

	// fill the four interpolation tables
	task automatic fill_tables();
		longint unsigned one, e1, t, e, e2, z, z2, p, acc;
		one = 64'd1 << LUT_FRAC;
		e1 = series_exp(one);
		for (int i = 0; i <= TAB_N; i++) begin
			t = (longint'(i) << (LUT_FRAC + 5)) / TAB_N;
			e = decay(t, e1);
			e2 = decay(2 * t, e1);
			if (e > one) e = one;
			if (e2 > one) e2 = one;
			z = (e << LUT_FRAC) / (2 * one + e);
			z2 = (z * z) >> LUT_FRAC;
			p = z;
			acc = 0;
			for (int k = 0; k < 20; k++) begin
				acc += p / longint'(2 * k + 1);
				p = (p * z2) >> LUT_FRAC;
			end
			rom_q30[TAB_EXP][i] = e;
			rom_q30[TAB_SIG][i] = (one << LUT_FRAC) / (one + e);
			rom_q30[TAB_TANH][i] = ((one - e2) << LUT_FRAC) / (one + e2);
			rom_q30[TAB_SPL][i] = 2 * acc;
		end
	endtask

	function automatic longint unsigned interp(int sel, longint unsigned mag);
		longint unsigned pos, idx, frac, a, b;
		pos = mag * TAB_N;
		idx = pos >> 15;
		frac = pos & ((64'd1 << 15) - 1);
		if (idx >= TAB_N) return rom_q30[sel][TAB_N];
		a = rom_q30[sel][idx];
		b = rom_q30[sel][idx + 1];
		if (b >= a) return a + (((b - a) * frac) >> 15);
		return a - (((a - b) * frac) >> 15);
	endfunction

	function automatic longint unsigned q30_to_q16(longint unsigned v);
		return (v + (64'd1 << 13)) >> 14;
	endfunction

	function automatic longint unsigned logistic(logic signed [15:0] x, longint unsigned mag);
		longint unsigned s;
		s = interp(TAB_SIG, mag);
		return (x < 0) ? (64'd1 << LUT_FRAC) - s : s;
	endfunction

	// scaled activation or gradient of one element under the current registers
	function automatic act_result_t activate(logic k, logic signed [15:0] x,
			logic signed [15:0] g, logic eot);
		act_result_t r;
		longint unsigned scale, mag, gmag, xg, bmag, rmag, d, s, t, one;
		bit neg;
		one = 64'd1 << LUT_FRAC;
		scale = (out_scale == 0) ? 64'd4096 : 64'(out_scale);
		mag = (x < 0) ? 64'(-longint'(x)) : 64'(x);
		gmag = (g < 0) ? 64'(-longint'(g)) : 64'(g);
		neg = 0;
		if (!k) begin
			xg = mag << GUARD;
			case (fn_sel)
				FN_RELU: bmag = (x > 0) ? xg : 0;
				FN_SIGMOID: bmag = q30_to_q16(logistic(x, mag));
				FN_TANH: begin
					bmag = q30_to_q16(interp(TAB_TANH, mag));
					neg = x < 0;
				end
				FN_SOFTPLUS: begin
					if (x > SP_LIM_POS) bmag = xg;
					else if (x < SP_LIM_NEG) bmag = q30_to_q16(interp(TAB_EXP, mag));
					else if (x >= 0) bmag = xg + q30_to_q16(interp(TAB_SPL, mag));
					else bmag = q30_to_q16(interp(TAB_SPL, mag));
				end
				default: begin
					bmag = xg;
					neg = x < 0;
				end
			endcase
			rmag = (bmag * scale + (64'd1 << 17)) >> 18;
		end else begin
			case (fn_sel)
				FN_RELU: d = (x > 0) ? one : 0;
				FN_SIGMOID: begin
					s = logistic(x, mag);
					d = (s * (one - s)) >> LUT_FRAC;
				end
				FN_TANH: begin
					t = interp(TAB_TANH, mag);
					d = one - ((t * t) >> LUT_FRAC);
				end
				FN_SOFTPLUS: d = logistic(x, mag);
				default: d = one;
			endcase
			rmag = (gmag * scale * q30_to_q16(d) + (64'd1 << 27)) >> 28;
			neg = g < 0;
		end
		r.sat = 0;
		if (neg) begin
			if (rmag > 32768) begin
				rmag = 32768;
				r.sat = 1;
			end
			r.value = 16'(-rmag);
		end else begin
			if (rmag > 32767) begin
				rmag = 32767;
				r.sat = 1;
			end
			r.value = 16'(rmag);
		end
		r.eot = eot;
		return r;
	endfunction

	// track registers, queue expectations, check results
	always @(posedge clk) begin
		act_result_t e;
		if (!arst_n) begin
			fn_sel <= FN_RELU;
			out_scale <= 16'd4096;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FUNC) fn_sel <= cfg_data[2:0];
				else if (cfg_index == REG_SCALE) out_scale <= cfg_data;
			end
			if (start && !busy) begin
				e = activate(kind, x_value, grad_in, end_of_tensor);
				if (typed_en) begin
					e.value = typed_val;
					e.sat = typed_sat;
				end
				expected_results.push_back(e);
				if (kind) bwd_count++;
				else fwd_count++;
			end
			if (result_valid) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					e = expected_results.pop_front();
					if (result_value !== e.value)
						report_mismatch($sformatf("result_value %0d, want %0d",
							$signed(result_value), $signed(e.value)));
					if (saturated !== e.sat)
						report_mismatch($sformatf("saturated %b, want %b", saturated, e.sat));
					if (end_marker !== e.eot)
						report_mismatch($sformatf("end_marker %b, want %b", end_marker, e.eot));
					if (saturated === 1'b1) sat_count++;
				end
			end
		end
	end

	// drain, then hold for the pipeline before touching registers
	task automatic wait_idle();
		start <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		bit ok;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_request(input stim_row_t r, input int idle_pct);
		bit ok;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		kind <= r.kind;
		x_value <= r.x;
		grad_in <= r.g;
		end_of_tensor <= r.eot;
		typed_en <= r.typed;
		typed_val <= r.tv;
		typed_sat <= r.ts;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
	endtask

	function automatic stim_row_t row(logic [2:0] fn, logic [15:0] sc, logic k,
			logic [15:0] x, logic [15:0] g, bit typed, logic [15:0] tv, logic ts);
		stim_row_t r;
		r.fn = fn; r.scale = sc; r.kind = k; r.x = x; r.g = g;
		r.eot = x[0]; r.typed = typed; r.tv = tv; r.ts = ts;
		return r;
	endfunction

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		logic [2:0]  cur_fn;
		logic [15:0] cur_scale;
		int idle_pct;
		int guard_cycles;

		clk = 0;
		arst_n <= 0;
		start <= 0;
		kind <= 0;
		x_value <= 0;
		grad_in <= 0;
		end_of_tensor <= 0;
		cfg_valid <= 0;
		cfg_index <= REG_FUNC;
		cfg_data <= 0;
		typed_en <= 0;
		typed_val <= 0;
		typed_sat <= 0;
		fill_tables();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset registers: relu at unit scale
		rows.push_back(row(FN_RELU, 16'd4096, 0, 16'h7fff, 16'h0, 1, 16'h7fff, 0));
		rows.push_back(row(FN_RELU, 16'd4096, 0, 16'h8000, 16'h0, 1, 16'h0, 0));
		rows.push_back(row(FN_RELU, 16'd4096, 1, 16'h0001, 16'h8000, 1, 16'h8000, 0));
		rows.push_back(row(FN_RELU, 16'd4096, 1, 16'h0000, 16'h7fff, 1, 16'h0, 0));
		rows.push_back(row(FN_RELU, 16'd4096, 1, 16'h0005, 16'h7fff, 1, 16'h7fff, 0));
		// identity at the largest scale clips both ways
		rows.push_back(row(FN_IDENT, 16'hffff, 0, 16'h7fff, 16'h0, 1, 16'h7fff, 1));
		rows.push_back(row(FN_IDENT, 16'hffff, 0, 16'h8000, 16'h0, 1, 16'h8000, 1));
		rows.push_back(row(FN_IDENT, 16'hffff, 1, 16'h1234, 16'h8000, 1, 16'h8000, 1));
		// zero scale acts as unit scale
		rows.push_back(row(FN_IDENT, 16'h0000, 0, 16'd1000, 16'h0, 1, 16'd1000, 0));
		rows.push_back(row(FN_IDENT, 16'h0001, 0, 16'h7fff, 16'h0, 0, 0, 0));
		// unused selector code behaves as identity
		rows.push_back(row(3'd7, 16'd4096, 0, -16'sd5, 16'h0, 1, -16'sd5, 0));
		rows.push_back(row(FN_SIGMOID, 16'd4096, 0, 16'h0000, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SIGMOID, 16'd4096, 0, 16'h8000, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SIGMOID, 16'd4096, 1, 16'h0000, 16'h7fff, 0, 0, 0));
		rows.push_back(row(FN_TANH, 16'd4096, 0, -16'sd700, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_TANH, 16'd4096, 1, 16'd300, 16'h8000, 0, 0, 0));
		// softplus thresholds are strict
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 0, 16'd20480, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 0, 16'd20481, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 0, -16'sd20480, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 0, -16'sd20481, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 0, 16'h0000, 16'h0, 0, 0, 0));
		rows.push_back(row(FN_SOFTPLUS, 16'd4096, 1, 16'h8000, 16'h7fff, 0, 0, 0));

		cur_fn = FN_RELU;
		cur_scale = 16'd4096;
		foreach (rows[i]) begin
			if (rows[i].fn != cur_fn || rows[i].scale != cur_scale) begin
				wait_idle();
				write_reg(REG_FUNC, {13'h0, rows[i].fn});
				write_reg(REG_SCALE, rows[i].scale);
				cur_fn = rows[i].fn;
				cur_scale = rows[i].scale;
			end
			send_request(rows[i], 0);
		end

		// random segments, each under its own register setting
		for (int seg = 0; seg < 12; seg++) begin
			idle_pct = (seg < 4) ? 24 : (seg < 8) ? 58 : 0;
			wait_idle();
			// indexes past the list must leave the registers alone
			write_reg(2'd2, 16'($urandom));
			write_reg(REG_FUNC, 16'((seg < 10) ? seg % 5 : $urandom_range(5, 7)) |
				16'($urandom_range(0, 8191) << 3));
			case (seg % 5)
				0: write_reg(REG_SCALE, 16'd4096);
				1: write_reg(REG_SCALE, 16'hffff);
				2: write_reg(REG_SCALE, 16'h0001);
				3: write_reg(REG_SCALE, 16'h0000);
				default: write_reg(REG_SCALE, 16'($urandom));
			endcase
			write_reg(2'd3, 16'($urandom));
			for (int n = 0; n < 107; n++) begin
				r.fn = 0;
				r.scale = 0;
				r.kind = $urandom_range(0, 1);
				if ($urandom_range(0, 1)) r.x = 16'($urandom);
				else r.x = 16'($signed($urandom_range(0, 49152)) - 24576);
				r.g = 16'($urandom);
				r.eot = ($urandom_range(0, 15) == 0);
				r.typed = 0;
				r.tv = 0;
				r.ts = 0;
				send_request(r, idle_pct);
			end
		end
		start <= 0;
		typed_en <= 0;

		guard_cycles = 0;
		while (expected_results.size() != 0 && guard_cycles < 1000) begin
			@(posedge clk);
			guard_cycles++;
		end
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Covered %0d forward and %0d backward elements: directed corners, then",
			fwd_count, bwd_count);
		$display("12 random register settings; %0d results checked, %0d of them saturated.",
			result_count, sat_count);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
